// File: rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Opcodes, status codes and payload types of the sorted insertion list.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned StatusW = 2;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [OpcodeW-1:0]       opcode_t;
  typedef logic [StatusW-1:0]       status_t;

  localparam opcode_t OP_INSERT    = 2'd0;
  localparam opcode_t OP_READ_ASC  = 2'd1;
  localparam opcode_t OP_READ_DESC = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// File: rtl/sil_ram.sv
// ----------------------------------------------------------------------------
// sil_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sil_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sorted_insertion_list.sv
// ----------------------------------------------------------------------------
// sorted_insertion_list
// Bounded store of signed values kept in ascending order in one RAM.
// Inserts go after equal values; reads stream all values either way.
//
//   channel | signals                                  | item
//   in      | in_valid in_ready in_opcode in_value     | insert or read request
//   out     | out_valid out_ready out_value out_last   | one result per value,
//           | out_status                               | or one status result
//
// Insert: a top-down compare and shift through the RAM read port moves each
// held entry greater than the value up one slot; the value is written into
// the slot above the first entry not greater (at slot 0 if none), then the
// result is posted; an insert into an empty store writes at accept.
// Read: one result per cycle while out_ready stays high, paced by the RAM
// read latency overlapped with the output register.
// Reset clears the state, the held count and out_valid; the RAM needs no clearing. A stalled
// output holds the sequencer; one item is in work at a time.
// ----------------------------------------------------------------------------
module sorted_insertion_list
  import sil_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  opcode_t in_opcode,
  input  value_t  in_value,
  output logic    out_valid,
  input  logic    out_ready,
  output value_t  out_value,
  output logic    out_last,
  output status_t out_status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT0 = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          desc_r, desc_nxt;
  value_t        val_r, val_nxt;
  status_t       resp_r, resp_nxt;

  logic    out_valid_r, out_valid_nxt;
  value_t  out_value_r, out_value_nxt;
  logic    out_last_r, out_last_nxt;
  status_t out_status_r, out_status_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  value_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  value_t        ram_rdata;

  logic          slot_free;
  logic          accept;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] ptr_step;

  sil_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cnt_m1    = count_r - CW'(1);
  assign ptr_step  = desc_r ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    desc_nxt       = desc_r;
    val_nxt        = val_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r + AW'(1);
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          case (in_opcode)
            OP_INSERT: begin
              if (count_r >= CW'(DEPTH)) begin
                resp_nxt  = ST_FULL;
                state_nxt = S_RESP;
              end else if (count_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_value;
                count_nxt = count_r + CW'(1);
                resp_nxt  = ST_OK;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[AW-1:0];
                ptr_nxt   = cnt_m1[AW-1:0];
                state_nxt = S_INS;
              end
            end
            OP_READ_ASC, OP_READ_DESC: begin
              if (count_r == '0) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                desc_nxt  = (in_opcode == OP_READ_DESC);
                ram_re    = 1'b1;
                ram_raddr = (in_opcode == OP_READ_DESC) ? cnt_m1[AW-1:0] : '0;
                ptr_nxt   = ram_raddr;
                rem_nxt   = cnt_m1;
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS: begin
        if (ram_rdata > val_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          if (ptr_r == '0) begin
            state_nxt = S_PUT0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r - AW'(1);
            ptr_nxt   = ptr_r - AW'(1);
          end
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          resp_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end

      S_PUT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_nxt = count_r + CW'(1);
        resp_nxt  = ST_OK;
        state_nxt = S_RESP;
      end

      S_RD: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = ram_rdata;
          out_last_nxt   = (rem_r == '0);
          out_status_nxt = ST_OK;
          if (rem_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_step;
            ptr_nxt   = ptr_step;
            rem_nxt   = rem_r - CW'(1);
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = resp_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    rem_r        <= rem_nxt;
    desc_r       <= desc_nxt;
    val_r        <= val_nxt;
    resp_r       <= resp_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

// File: test/sorted_insertion_list_test.sv
// ----------------------------------------------------------------------------
// sorted_insertion_list_test
// Self-checking bench for the sorted insertion list. A short table of
// directed items (empty reads, extreme and equal values, the unused opcode)
// is followed by random inserts and reads that fill the store to its limit
// and then keep hitting the full-store drop. Every result is compared with a
// behavioral copy of the sorted store; both channels stall at random.
// ----------------------------------------------------------------------------
module sorted_insertion_list_test;
  import sil_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam opcode_t OP_UNUSED = 2'd3;

  typedef struct packed {
    value_t  value;
    logic    last;
    status_t status;
  } result_t;

  typedef struct packed {
    opcode_t op;
    value_t  value;
    logic    pinned;
    result_t want;
  } row_t;

  localparam logic PINNED = 1'b1;
  localparam logic FREE   = 1'b0;
  localparam result_t OK_RES    = {32'sd0, 1'b1, ST_OK};
  localparam result_t FULL_RES  = {32'sd0, 1'b1, ST_FULL};
  localparam result_t EMPTY_RES = {32'sd0, 1'b1, ST_EMPTY};
  localparam result_t NO_RES    = '0;

  localparam int unsigned PLAN_ROWS = 18;
  localparam row_t PLAN [PLAN_ROWS] = '{
    {OP_READ_ASC,  32'sh0000_0000, PINNED, EMPTY_RES},
    {OP_READ_DESC, 32'sh1234_5678, PINNED, EMPTY_RES},
    {OP_UNUSED,    32'sh0000_0007, FREE,   NO_RES},
    {OP_INSERT,    32'sh7fff_ffff, PINNED, OK_RES},
    {OP_INSERT,    32'sh8000_0000, PINNED, OK_RES},
    {OP_READ_ASC,  32'sh0000_0000, FREE,   NO_RES},
    {OP_INSERT,    32'sh0000_0000, PINNED, OK_RES},
    {OP_INSERT,    32'sh0000_0000, PINNED, OK_RES},
    {OP_INSERT,    32'shffff_ffff, PINNED, OK_RES},
    {OP_INSERT,    32'sh0000_0001, PINNED, OK_RES},
    {OP_INSERT,    32'sh7fff_ffff, PINNED, OK_RES},
    {OP_INSERT,    32'sh8000_0000, PINNED, OK_RES},
    {OP_READ_ASC,  32'shffff_ffff, FREE,   NO_RES},
    {OP_READ_DESC, 32'sh0000_0000, FREE,   NO_RES},
    {OP_UNUSED,    32'shffff_ffff, FREE,   NO_RES},
    {OP_INSERT,    32'sh5555_5555, PINNED, OK_RES},
    {OP_INSERT,    32'shaaaa_aaaa, PINNED, OK_RES},
    {OP_READ_DESC, 32'sh0000_0000, FREE,   NO_RES}
  };

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  opcode_t in_opcode;
  value_t  in_value;
  logic    out_valid;
  logic    out_ready;
  value_t  out_value;
  logic    out_last;
  status_t out_status;

  value_t      held_vals [DEPTH];
  int unsigned held_n;
  result_t     new_results [$];
  result_t     due_results [$];
  logic        steady;
  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_full;
  int unsigned n_empty;

  sorted_insertion_list #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_last  (out_last),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("sorted_insertion_list_test: errors");
    $finish;
  end

  function automatic void predict_sorted(opcode_t op, value_t v);
    int unsigned pos;
    int unsigned i;
    int unsigned idx;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (held_n >= DEPTH) begin
          new_results.push_back(FULL_RES);
        end else begin
          while (pos < held_n && !(v < held_vals[pos])) pos++;
          for (i = held_n; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = v;
          held_n++;
          new_results.push_back(OK_RES);
        end
      end
      OP_READ_ASC, OP_READ_DESC: begin
        if (held_n == 0) begin
          new_results.push_back(EMPTY_RES);
        end else begin
          for (i = 0; i < held_n; i++) begin
            idx = (op == OP_READ_ASC) ? i : held_n - 1 - i;
            new_results.push_back({held_vals[idx], i == held_n - 1, ST_OK});
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // enter and leave at a falling edge
  task automatic send_item(opcode_t op, value_t v, logic pinned, result_t pinned_res);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
    new_results.delete();
    predict_sorted(op, v);
    foreach (new_results[k]) begin
      if (new_results[k].status == ST_FULL) n_full++;
      if (new_results[k].status == ST_EMPTY) n_empty++;
    end
    if (pinned) due_results.push_back(pinned_res);
    else foreach (new_results[k]) due_results.push_back(new_results[k]);
    n_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected item", out_value, 32'h0);
      end else begin
        want = due_results.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_last !== want.last)
          report_mismatch("last", {31'b0, out_last}, {31'b0, want.last});
        if (out_status !== want.status)
          report_mismatch("status", {30'b0, out_status}, {30'b0, want.status});
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned pick;
    opcode_t op;
    value_t v;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = OP_INSERT;
    in_value  = '0;
    steady    = 1'b0;
    held_n    = 0;
    errors    = 0;
    n_sent    = 0;
    n_checked = 0;
    n_full    = 0;
    n_empty   = 0;
    counted   = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < PLAN_ROWS; r++)
      send_item(PLAN[r].op, PLAN[r].value, PLAN[r].pinned, PLAN[r].want);

    while (counted < RANDOM_ITEMS) begin
      steady = (counted >= 80 && counted < 130);
      pick = $urandom_range(99);
      if (pick < 25) op = OP_INSERT;
      else if (pick < 60) op = OP_READ_ASC;
      else if (pick < 95) op = OP_READ_DESC;
      else op = OP_UNUSED;
      pick = $urandom_range(7);
      if (pick < 2) v = $signed($urandom_range(4)) - 2;
      else if (pick == 2) v = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      else v = $urandom;
      send_item(op, v, FREE, NO_RES);
      if (op != OP_UNUSED) counted++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("sorted_insertion_list_test: %0d items sent, %0d results checked",
             n_sent, n_checked);
    $display("sorted_insertion_list_test: %0d held at end, %0d full drops, %0d empty reads",
             held_n, n_full, n_empty);
    if (errors == 0) $display("sorted_insertion_list_test: clean");
    else $display("sorted_insertion_list_test: errors");
    $finish;
  end

endmodule
